@@ rtl/core/erfsos_pkg.sv @@
// Package for the sum-of-sines error-function block: coefficient tables,
// pipeline geometry and the per-lane datapath record.
// Used by erf_sum_of_sines_approx; depends on nothing else.
package erfsos_pkg;

    localparam int NTERMS  = 8;
    localparam int LANE_W  = $clog2(NTERMS);
    localparam int HSTEPS  = 8;
    localparam int HSTEP_W = $clog2(HSTEPS);
    localparam int X_W     = 16;
    localparam int Y_W     = 16;

    // Lane stages: phase, quotient estimate, reduce, wrap, fold, square,
    // four per series step, sine, term. Then three adder-tree stages and
    // the output register.
    localparam int ST_HORNER = 6;
    localparam int ST_SINE   = ST_HORNER + 4 * HSTEPS;
    localparam int ST_TERM   = ST_SINE + 1;
    localparam int LSTG      = ST_TERM + 1;
    localparam int NSTG      = LSTG + 4;

    // Radians in Q44.
    localparam logic signed [47:0] PI_Q44      = 48'sh3243F6A8885A;
    localparam logic signed [47:0] TWO_PI_Q44  = 48'sh6487ED5110B4;
    localparam logic signed [47:0] HALF_PI_Q44 = 48'sh1921FB54442D;

    // About 2^14 / (2*pi): turns (phase >>> 38) into turns in Q20.
    localparam logic signed [25:0] KINV = 26'sd2608;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam longint AMP_Q24 [NTERMS] = '{
        longint'(((64'd1213 << 24) + 64'd500) / 64'd1000),
        -longint'(((64'd9476 << 24) + 64'd50000) / 64'd100000),
        -longint'(((64'd1394 << 24) + 64'd50) / 64'd100),
        -longint'(((64'd1488 << 24) + 64'd5000) / 64'd10000),
        -longint'(((64'd1396 << 24) + 64'd50) / 64'd100),
        -longint'(((64'd2845 << 24) + 64'd5000) / 64'd10000),
        -longint'(((64'd3579 << 24) + 64'd50000000) / 64'd100000000),
        -longint'(((64'd2665 << 24) + 64'd500000) / 64'd1000000)
    };

    localparam longint FREQ_Q32 [NTERMS] = '{
        longint'(((64'd4524 << 32) + 64'd5000) / 64'd10000),
        longint'(((64'd1972 << 32) + 64'd500) / 64'd1000),
        longint'(((64'd2935 << 32) + 64'd500) / 64'd1000),
        longint'(((64'd2152 << 32) + 64'd500) / 64'd1000),
        longint'(((64'd2935 << 32) + 64'd500) / 64'd1000),
        longint'(((64'd1383 << 32) + 64'd500) / 64'd1000),
        longint'(((64'd8485 << 32) + 64'd500) / 64'd1000),
        longint'(((64'd4001 << 32) + 64'd500) / 64'd1000)
    };

    localparam longint OFFS_Q44 [NTERMS] = '{
        longint'(((64'd7816 << 44) + 64'd5000000000000) / 64'd10000000000000),
        -longint'(((64'd3286 << 44) + 64'd5000000000) / 64'd10000000000),
        -longint'(((64'd2073 << 44) + 64'd5000000000) / 64'd10000000000),
        -longint'(((64'd3142 << 44) + 64'd500) / 64'd1000),
        -longint'(((64'd3142 << 44) + 64'd500) / 64'd1000),
        -longint'(((64'd3142 << 44) + 64'd500) / 64'd1000),
        longint'(((64'd95 << 44) + 64'd50000000) / 64'd100000000),
        -longint'(((64'd3142 << 44) + 64'd500) / 64'd1000)
    };

    // Series divisors (2n)(2n+1) for n = 8 down to 1, and floor(2^32 / d).
    localparam logic [8:0] HDIV [HSTEPS] = '{
        9'd272, 9'd210, 9'd156, 9'd110, 9'd72, 9'd42, 9'd20, 9'd6
    };
    localparam logic [29:0] HREC [HSTEPS] = '{
        30'((64'd1 << 32) / 64'd272), 30'((64'd1 << 32) / 64'd210),
        30'((64'd1 << 32) / 64'd156), 30'((64'd1 << 32) / 64'd110),
        30'((64'd1 << 32) / 64'd72),  30'((64'd1 << 32) / 64'd42),
        30'((64'd1 << 32) / 64'd20),  30'((64'd1 << 32) / 64'd6)
    };

    typedef struct packed {
        logic signed [53:0] ph;    // phase, Q44
        logic signed [25:0] tq;    // turns estimate, Q20
        logic signed [47:0] r;     // phase less whole turns
        logic               neg;
        logic [46:0]        m;     // magnitude of wrapped phase
        logic [30:0]        m30;   // folded phase, Q30
        logic [31:0]        r2;    // its square, Q30
        logic [30:0]        s;     // series accumulator, Q30
        logic [31:0]        t;
        logic [61:0]        p;
        logic [31:0]        qe;
        logic [31:0]        rem;
        logic signed [31:0] sine;  // Q30
        logic signed [60:0] term;  // Q54
    } lane_t;

endpackage

@@ rtl/core/erf_sum_of_sines_approx.sv @@
// Error-function approximation as a sum of eight sines, fully pipelined.
// Depends on erfsos_pkg for coefficients, stage counts and the lane record.
//
// One argument x (signed Q3.12) enters per beat and one result (signed
// Q1.14, rounded to nearest and saturated) leaves per beat, one beat per
// clock when the output side is ready. Eight parallel lanes each form
// b_k*x + c_k, reduce it modulo 2*pi, fold it to [0, pi/2] and evaluate
// the sine by an eight-step Horner series of four stages per step, then
// scale by a_k; a three-level adder tree and a rounding stage follow. The
// whole pipeline advances together and holds when a result is offered
// and not taken.
module erf_sum_of_sines_approx (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [erfsos_pkg::X_W-1:0]   s_tdata,   // [15:0] x_value
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [erfsos_pkg::Y_W-1:0]   m_tdata    // [15:0] erf_approx
);
    import erfsos_pkg::*;

    function automatic lane_t lane_step(input int stg, input logic [LANE_W-1:0] k,
                                        input lane_t a, input logic signed [X_W-1:0] x);
        lane_t                    o;
        int                       rel;
        logic [HSTEP_W-1:0]       j;
        logic signed [5:0]        q0;
        logic signed [47:0]       rr;
        logic [46:0]              mm;
        logic [63:0]              wide;
        logic [31:0]              qv;
        o   = a;
        rel = stg - ST_HORNER;
        j   = HSTEP_W'(rel >> 2);
        if (stg == 0) begin
            o.ph = 54'(FREQ_Q32[k]) * 54'(x) + 54'(OFFS_Q44[k]);
        end else if (stg == 1) begin
            o.tq = 26'(a.ph >>> 38) * KINV + 26'sd524288;
        end else if (stg == 2) begin
            q0  = 6'(a.tq >>> 20);
            o.r = 48'(a.ph - 54'(q0) * 54'(TWO_PI_Q44));
        end else if (stg == 3) begin
            rr = a.r;
            if (rr >= PI_Q44) begin
                rr = rr - TWO_PI_Q44;
            end else if (rr < -PI_Q44) begin
                rr = rr + TWO_PI_Q44;
            end
            o.neg = rr[47];
            o.m   = 47'(rr[47] ? -rr : rr);
        end else if (stg == 4) begin
            mm = a.m;
            if (mm > 47'(HALF_PI_Q44)) begin
                mm = 47'(PI_Q44) - mm;
            end
            o.m30 = 31'((mm + 47'd8192) >> 14);
        end else if (stg == 5) begin
            wide = 64'(a.m30) * 64'(a.m30) + 64'h2000_0000;
            o.r2 = 32'(wide >> 30);
            o.s  = ONE_Q30;
        end else if (stg < ST_SINE) begin
            case (rel[1:0])
                2'd0: begin
                    wide = 64'(a.r2) * 64'(a.s);
                    o.t  = 32'(wide >> 30);
                end
                2'd1: begin
                    o.p = 62'(a.t) * 62'(HREC[j]);
                end
                2'd2: begin
                    qv    = 32'(a.p >> 32);
                    o.qe  = qv;
                    o.rem = a.t - 32'(64'(qv) * 64'(HDIV[j]));
                end
                default: begin
                    // The reciprocal estimate is at most one short.
                    qv  = a.qe + ((a.rem >= 32'(HDIV[j])) ? 32'd1 : 32'd0);
                    o.s = ONE_Q30 - 31'(qv);
                end
            endcase
        end else if (stg == ST_SINE) begin
            wide   = (64'(a.m30) * 64'(a.s) + 64'h2000_0000) >> 30;
            o.sine = a.neg ? -32'(wide) : 32'(wide);
        end else begin
            o.term = 61'(AMP_Q24[k]) * 61'(a.sine);
        end
        return o;
    endfunction

    logic              en;
    logic [NSTG-1:0]   vld_reg;
    lane_t             lane_reg  [LSTG][NTERMS];
    lane_t             lane_next [LSTG][NTERMS];
    logic signed [63:0] t1_reg [4];
    logic signed [63:0] t2_reg [2];
    logic signed [63:0] t3_reg;
    logic [Y_W-1:0]    y_reg;
    logic [Y_W-1:0]    y_next;
    logic signed [63:0] w;

    assign en       = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = y_reg;

    for (genvar g = 0; g < LSTG; g++) begin : g_stage
        for (genvar k = 0; k < NTERMS; k++) begin : g_lane
            if (g == 0) begin : g_first
                always_comb
                begin
                    lane_next[g][k] = lane_step(g, LANE_W'(k), '0, s_tdata);
                end
            end else begin : g_rest
                always_comb
                begin
                    lane_next[g][k] = lane_step(g, LANE_W'(k), lane_reg[g-1][k], s_tdata);
                end
            end
        end
    end

    // Floor of (sum + half LSB) in Q14, then clamp.
    always_comb
    begin
        w = (t3_reg + 64'sh80_0000_0000) >>> 40;
        if (w < -64'sd32768) begin
            y_next = 16'h8000;
        end else if (w > 64'sd32767) begin
            y_next = 16'h7FFF;
        end else begin
            y_next = w[Y_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            lane_reg <= lane_next;
            for (int i = 0; i < 4; i++) begin
                t1_reg[i] <= 64'(lane_reg[LSTG-1][2*i].term)
                           + 64'(lane_reg[LSTG-1][2*i+1].term);
            end
            t2_reg[0] <= t1_reg[0] + t1_reg[1];
            t2_reg[1] <= t1_reg[2] + t1_reg[3];
            t3_reg    <= t2_reg[0] + t2_reg[1];
            y_reg     <= y_next;
        end
    end

endmodule

@@ rtl/core/erfsos_chk.sv @@
// Port-level checks for erf_sum_of_sines_approx and the bind that attaches them.
// Depends only on the top level's ports.
module erfsos_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A ready output side never stalls the input side.
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output ready");

    // The input side stalls only behind a result that is offered and not taken.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output beat withdrawn");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("stalled output beat changed");

endmodule

bind erf_sum_of_sines_approx erfsos_chk u_erfsos_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
